>>> hdl/median_of_medians_filter_3x3_macros.svh
// Assertion macros for the 3x3 median-of-medians filter.
// Used by the top level; needs nothing else.
`ifndef MEDIAN_OF_MEDIANS_FILTER_3X3_MACROS_SVH
`define MEDIAN_OF_MEDIANS_FILTER_3X3_MACROS_SVH

// same-cycle implication, disabled in reset
`define MMF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define MMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/mmf_pkg.sv
// Shared types, constants and the median-of-three function for the
// 3x3 median-of-medians filter. No dependencies.
`timescale 1ns / 1ps

package mmf_pkg;

   localparam int PIXEL_BITS        = 8;
   localparam int MAX_WIDTH_DEFAULT = 512;
   localparam int WIDTH_BITS        = 10;
   localparam int HEIGHT_BITS       = 13;
   localparam int CSR_DATA_BITS     = 13;
   localparam int CSR_INDEX_BITS    = 1;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 10'd512;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd512;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic      mode;
      pixel_type pixel;
   } req_word_type;

   typedef struct packed {
      pixel_type out_pixel;
      logic      end_of_row;
      logic      end_of_frame;
      logic      last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic shift;
      logic first_col;
   } win_ctl_type;

   typedef struct packed {
      logic upper;
      logic middle;
   } ls_we_type;

   function automatic pixel_type med3(pixel_type a, pixel_type b, pixel_type c);
      pixel_type lo;
      pixel_type hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c <= lo) begin
         return lo;
      end else if (c >= hi) begin
         return hi;
      end
      return c;
   endfunction

endpackage

>>> hdl/mmf_line_store.sv
// Two line buffers (upper row, middle row), one write and one registered
// read per buffer per cycle. Depends on mmf_pkg.
`timescale 1ns / 1ps

module mmf_line_store #(
   parameter int DEPTH = mmf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  mmf_pkg::ls_we_type      wr_we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  mmf_pkg::pixel_type      wr_upper,
   input  mmf_pkg::pixel_type      wr_middle,
   output mmf_pkg::pixel_type      rd_upper,
   output mmf_pkg::pixel_type      rd_middle
);

   mmf_pkg::pixel_type upper_mem  [DEPTH];
   mmf_pkg::pixel_type middle_mem [DEPTH];
   mmf_pkg::pixel_type upper_q_ff;
   mmf_pkg::pixel_type middle_q_ff;

   always_ff @(posedge clock) begin
      if (wr_we.upper) begin
         upper_mem[wr_addr] <= wr_upper;
      end
      if (wr_we.middle) begin
         middle_mem[wr_addr] <= wr_middle;
      end
      if (rd_en) begin
         upper_q_ff  <= upper_mem[rd_addr];
         middle_q_ff <= middle_mem[rd_addr];
      end
   end

   assign rd_upper  = upper_q_ff;
   assign rd_middle = middle_q_ff;

endmodule

>>> hdl/mmf_window.sv
// 3x3 window register and the two median-of-row-medians datapaths
// (interior and right-edge). Depends on mmf_pkg.
`timescale 1ns / 1ps

module mmf_window (
   input  logic                 clock,
   input  logic                 reset,
   input  mmf_pkg::win_ctl_type ctl,
   input  mmf_pkg::pixel_type   col_top,
   input  mmf_pkg::pixel_type   col_mid,
   input  mmf_pkg::pixel_type   col_bot,
   output mmf_pkg::pixel_type   med_full,
   output mmf_pkg::pixel_type   med_edge
);

   mmf_pkg::pixel_type win_ff   [0:2][0:2];
   mmf_pkg::pixel_type win_in   [0:2][0:2];
   mmf_pkg::pixel_type col      [0:2];
   mmf_pkg::pixel_type row_full [0:2];
   mmf_pkg::pixel_type row_edge [0:2];

   assign col[0] = col_top;
   assign col[1] = col_mid;
   assign col[2] = col_bot;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (ctl.first_col) begin
            win_in[k][0] = col[k];
            win_in[k][1] = col[k];
         end else begin
            win_in[k][0] = win_ff[k][1];
            win_in[k][1] = win_ff[k][2];
         end
         win_in[k][2] = col[k];
         row_full[k] = mmf_pkg::med3(win_in[k][0], win_in[k][1], win_in[k][2]);
         row_edge[k] = mmf_pkg::med3(win_in[k][1], win_in[k][2], win_in[k][2]);
      end
   end

   assign med_full = mmf_pkg::med3(row_full[0], row_full[1], row_full[2]);
   assign med_edge = mmf_pkg::med3(row_edge[0], row_edge[1], row_edge[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (ctl.shift) begin
         win_ff <= win_in;
      end
   end

endmodule

>>> hdl/median_of_medians_filter_3x3.sv
// A word is registered in the input stage; its results then go to the two-word
// output buffer that drives rsp_valid. Words of the first image row give no result.
// Throughput: one word per cycle while the two-word output buffer has room for all
// results of the word; the last word of each row yields two results.
// Reset (synchronous): clears counters and window, empties input stage and output
// buffer and sets both registers to 512; line buffers are not cleared and need no pass.
`timescale 1ns / 1ps
`include "median_of_medians_filter_3x3_macros.svh"

module median_of_medians_filter_3x3 #(
   parameter int MAX_WIDTH = mmf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mmf_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mmf_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_write,
   input  logic [mmf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mmf_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WB  = mmf_pkg::WIDTH_BITS;
   localparam int HB  = mmf_pkg::HEIGHT_BITS;
   localparam int WEW = (CW + 1 > WB) ? CW + 1 : WB;

   logic [WB-1:0] width_ff;
   logic [HB-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mmf_pkg::WIDTH_RESET;
         height_ff <= mmf_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            mmf_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[WB-1:0];
            end
            mmf_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[HB-1:0];
            end
            default: ;
         endcase
      end
   end

   logic           req_accept;
   logic           s1_fire;
   logic           s1_valid_ff;
   logic [CW-1:0]  col_ff, col_in;
   logic [HB-1:0]  row_ff, row_in;
   logic [WEW-1:0] width_ext, width_eff;
   logic [HB-1:0]  height_eff;
   logic           drain, last_col;

   assign req_stall  = s1_valid_ff & ~s1_fire;
   assign req_accept = req_valid & ~req_stall;

   assign width_ext  = WEW'(width_ff);
   assign width_eff  = (width_ff < WB'(2)) ? WEW'(2) :
                       (width_ext > WEW'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : width_ext;
   assign height_eff = (height_ff < HB'(2)) ? HB'(2) : height_ff;
   assign drain      = row_ff >= height_eff;
   assign last_col   = WEW'(col_ff) >= (width_eff - WEW'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = drain ? '0 : row_ff + HB'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // input stage
   logic               s1_valid_in;
   logic [CW-1:0]      s1_col_ff;
   logic               s1_row0_ff, s1_row1_ff, s1_drain_ff, s1_last_ff;
   logic               s1_first_ff, s1_flush_ff;
   mmf_pkg::pixel_type s1_pixel_ff;

   assign s1_valid_in = req_accept | (s1_valid_ff & ~s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff   <= col_ff;
         s1_row0_ff  <= row_ff == '0;
         s1_row1_ff  <= row_ff == HB'(1);
         s1_drain_ff <= drain;
         s1_last_ff  <= last_col;
         s1_first_ff <= col_ff == '0;
         s1_flush_ff <= drain | (req_word.mode == mmf_pkg::MODE_FLUSH);
         s1_pixel_ff <= req_word.pixel;
      end
   end

   mmf_pkg::pixel_type  rd_upper, rd_middle, top_px, bot_px;
   mmf_pkg::ls_we_type  ls_we;
   mmf_pkg::win_ctl_type win_ctl;
   mmf_pkg::pixel_type  med_full, med_edge;

   assign top_px = s1_row1_ff ? rd_middle : rd_upper;
   assign bot_px = s1_flush_ff ? (s1_row0_ff ? '0 : rd_middle) : s1_pixel_ff;

   assign ls_we.upper  = s1_fire & ~s1_row0_ff;
   assign ls_we.middle = s1_fire;

   assign win_ctl.shift     = s1_fire & ~s1_row0_ff;
   assign win_ctl.first_col = s1_first_ff;

   mmf_line_store #(
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock    (clock),
      .rd_en    (req_accept),
      .rd_addr  (col_ff),
      .wr_we    (ls_we),
      .wr_addr  (s1_col_ff),
      .wr_upper (rd_middle),
      .wr_middle(bot_px),
      .rd_upper (rd_upper),
      .rd_middle(rd_middle)
   );

   mmf_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .col_top (top_px),
      .col_mid (rd_middle),
      .col_bot (bot_px),
      .med_full(med_full),
      .med_edge(med_edge)
   );

   // result buffer, two words deep
   mmf_pkg::rsp_word_type res_a, res_b, res_0, res_1;
   mmf_pkg::rsp_word_type buf_ff [0:1];
   mmf_pkg::rsp_word_type buf_in [0:1];
   logic [1:0] cnt_ff, cnt_in, cnt_left, res_n;
   logic       pop;

   assign res_a = '{out_pixel: med_full, end_of_row: 1'b0, end_of_frame: 1'b0,
                    last_of_run: ~s1_last_ff};
   assign res_b = '{out_pixel: med_edge, end_of_row: 1'b1, end_of_frame: s1_drain_ff,
                    last_of_run: 1'b1};
   assign res_0 = s1_first_ff ? res_b : res_a;
   assign res_1 = res_b;
   assign res_n = s1_row0_ff ? 2'd0 :
                  ((s1_first_ff ? 2'd0 : 2'd1) + {1'b0, s1_last_ff});

   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_word  = buf_ff[0];
   assign pop       = rsp_valid & ~rsp_stall;
   assign cnt_left  = cnt_ff - 2'(pop);
   assign s1_fire   = s1_valid_ff & ((3'(cnt_left) + 3'(res_n)) <= 3'd2);

   always_comb begin
      buf_in[0] = pop ? buf_ff[1] : buf_ff[0];
      buf_in[1] = buf_ff[1];
      cnt_in    = cnt_left;
      if (s1_fire) begin
         case (cnt_left)
            2'd0: begin
               buf_in[0] = res_0;
               buf_in[1] = res_1;
            end
            2'd1: begin
               buf_in[1] = res_0;
            end
            default: ;
         endcase
         cnt_in = cnt_left + res_n;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `MMF_ASSERT_IMPLY(a_buf_bound, clock, reset, 1'b1, cnt_ff <= 2'd2, "result buffer overfilled")
   `MMF_ASSERT_IMPLY(a_ls_no_clash, clock, reset, req_accept && (ls_we.upper || ls_we.middle), s1_col_ff != col_ff, "line store read and write collide")
   `MMF_ASSERT_IMPLY(a_eof_is_eor, clock, reset, rsp_valid && rsp_word.end_of_frame, rsp_word.end_of_row && rsp_word.last_of_run, "frame end without row end")
   `MMF_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_fire, s1_valid_ff && $stable(s1_col_ff) && $stable(s1_pixel_ff), "stalled input stage lost its word")

endmodule

>>> dv/median_of_medians_filter_3x3_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for median_of_medians_filter_3x3: drives raster frames
// with random gaps and back-pressure and predicts every filtered word.
// Depends on mmf_pkg and the filter RTL only.

module median_of_medians_filter_3x3_test;
   import mmf_pkg::*;

   localparam int LINE_DEPTH    = MAX_WIDTH_DEFAULT;
   localparam int RANDOM_WORDS  = 420;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 400;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_word_type              req_word;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_word_type              rsp_word;
   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   pixel_type              upper_line [LINE_DEPTH];
   pixel_type              middle_line [LINE_DEPTH];
   pixel_type              win [3][3];
   int                     col_pos = 0;
   int                     row_pos = 0;
   logic [WIDTH_BITS-1:0]  width_reg = WIDTH_RESET;
   logic [HEIGHT_BITS-1:0] height_reg = HEIGHT_RESET;
   rsp_word_type           expected_pixels [$];
   int                     mismatch_count = 0;
   int                     words_sent = 0;
   bit                     no_idle = 1'b0;
   bit                     hold_request = 1'b0;

   median_of_medians_filter_3x3 #(
      .MAX_WIDTH(MAX_WIDTH_DEFAULT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int active_width();
      int w;
      w = int'(width_reg);
      if (w < 2) w = 2;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
   endfunction

   function automatic int active_height();
      int h;
      h = int'(height_reg);
      if (h < 2) h = 2;
      return h;
   endfunction

   function automatic pixel_type middle_of_three(pixel_type a, pixel_type b, pixel_type c);
      if (a > b) begin
         return (b > c) ? b : ((a > c) ? c : a);
      end
      return (a > c) ? a : ((b > c) ? c : b);
   endfunction

   function automatic pixel_type window_median(int x, int y, int z);
      pixel_type row_med [3];
      for (int k = 0; k < 3; k++) begin
         row_med[k] = middle_of_three(win[k][x], win[k][y], win[k][z]);
      end
      return middle_of_three(row_med[0], row_med[1], row_med[2]);
   endfunction

   function automatic void push_pixel(pixel_type v, logic eor, logic eof, logic last);
      rsp_word_type e;
      e.out_pixel    = v;
      e.end_of_row   = eor;
      e.end_of_frame = eof;
      e.last_of_run  = last;
      expected_pixels.push_back(e);
   endfunction

   function automatic void filter_predict(req_word_type w);
      int        c;
      int        r;
      bit        drain;
      bit        last_col;
      pixel_type v;
      pixel_type top;
      pixel_type mid;
      pixel_type column [3];
      c = col_pos;
      r = row_pos;
      if (c >= LINE_DEPTH) c = LINE_DEPTH - 1;
      drain    = (r >= active_height());
      last_col = (c >= active_width() - 1);
      mid = middle_line[c];
      top = (r == 1) ? mid : upper_line[c];
      if (drain || w.mode == MODE_FLUSH) begin
         v = (r == 0) ? '0 : mid;
      end else begin
         v = w.pixel;
      end
      if (r == 0) begin
         middle_line[c] = v;
      end else begin
         column = '{top, mid, v};
         for (int k = 0; k < 3; k++) begin
            if (c == 0) begin
               win[k][0] = column[k];
               win[k][1] = column[k];
            end else begin
               win[k][0] = win[k][1];
               win[k][1] = win[k][2];
            end
            win[k][2] = column[k];
         end
         upper_line[c]  = mid;
         middle_line[c] = v;
         if (c != 0) push_pixel(window_median(0, 1, 2), 1'b0, 1'b0, !last_col);
         if (last_col) push_pixel(window_median(1, 2, 2), 1'b1, drain, 1'b1);
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = drain ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic int idle_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return $urandom_range(1, 2);
      if (p < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic pixel_type pick_pixel();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         1: return pixel_type'($urandom_range(100, 102));
         default: return pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_word_type next_word();
      req_word_type w;
      w.pixel = pick_pixel();
      if (row_pos >= active_height()) begin
         w.mode = $urandom_range(0, 1) ? MODE_FLUSH : MODE_PIXEL;
      end else begin
         w.mode = ($urandom_range(0, 11) == 0) ? MODE_FLUSH : MODE_PIXEL;
      end
      return w;
   endfunction

   // receiver: random stalls, quiet stretches, one long hold on request
   initial begin
      int run;
      bit level;
      forever begin
         if (hold_request) begin
            level        = 1'b1;
            run          = HOLD_CYCLES;
            hold_request = 1'b0;
         end else if (no_idle) begin
            level = 1'b0;
            run   = 1;
         end else begin
            level = ($urandom_range(0, 3) == 0);
            run   = level ? idle_length() : $urandom_range(1, 12);
         end
         rsp_stall <= level;
         repeat (run) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_outputs
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word, actual pixel %0d eor %b eof %b last %b", $time,
                     rsp_word.out_pixel, rsp_word.end_of_row, rsp_word.end_of_frame,
                     rsp_word.last_of_run);
         end else begin
            e = expected_pixels.pop_front();
            if (rsp_word !== e) begin
               mismatch_count++;
               $display("%0t: mismatch, expected pixel %0d eor %b eof %b last %b", $time,
                        e.out_pixel, e.end_of_row, e.end_of_frame, e.last_of_run);
               $display("%0t:           actual   pixel %0d eor %b eof %b last %b", $time,
                        rsp_word.out_pixel, rsp_word.end_of_row, rsp_word.end_of_frame,
                        rsp_word.last_of_run);
            end
         end
      end
   end

   task automatic send_word(input req_word_type w);
      int gap;
      gap = no_idle ? 0 : (($urandom_range(0, 99) < 55) ? 0 : idle_length());
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      filter_predict(w);
      words_sent++;
   endtask

   task automatic send_words(input int count);
      repeat (count) send_word(next_word());
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx, input int value);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) begin
         width_reg = value[WIDTH_BITS-1:0];
      end else begin
         height_reg = value[HEIGHT_BITS-1:0];
      end
   endtask

   // send a frame to its end; optionally rewrite one register before word change_at
   task automatic send_frame(input int change_at, input logic [CSR_INDEX_BITS-1:0] change_index,
                             input int change_value);
      int n;
      n = 0;
      do begin
         if (n == change_at) write_register(change_index, change_value);
         send_word(next_word());
         n++;
      end while (row_pos != 0 || col_pos != 0);
   endtask

   // part of a row at the reset width, then narrow rows; end at the reset height cut short
   task automatic test_default_size();
      send_words(64);
      write_register(CSR_IMAGE_WIDTH, 4);
      send_words(9);
      send_frame(0, CSR_IMAGE_HEIGHT, 3);
   endtask

   task automatic test_special_cases();
      req_word_type words [$];
      write_register(CSR_IMAGE_WIDTH, 2);
      write_register(CSR_IMAGE_HEIGHT, 2);
      words = '{{MODE_PIXEL, 8'hFF}, {MODE_FLUSH, 8'h5A}, {MODE_PIXEL, 8'h00},
                {MODE_FLUSH, 8'hA5}, {MODE_PIXEL, 8'hAA}, {MODE_FLUSH, 8'h55}};
      foreach (words[i]) send_word(words[i]);
      write_register(CSR_IMAGE_WIDTH, 3);
      write_register(CSR_IMAGE_HEIGHT, 3);
      words = '{{MODE_PIXEL, 8'd9}, {MODE_PIXEL, 8'd9}, {MODE_PIXEL, 8'd7},
                {MODE_PIXEL, 8'd7}, {MODE_PIXEL, 8'd9}, {MODE_PIXEL, 8'd9},
                {MODE_PIXEL, 8'h55}, {MODE_PIXEL, 8'hAA}, {MODE_PIXEL, 8'hFF},
                {MODE_PIXEL, 8'h00}, {MODE_FLUSH, 8'h00}, {MODE_PIXEL, 8'hFF}};
      foreach (words[i]) send_word(words[i]);
   endtask

   task automatic test_register_limits();
      write_register(CSR_IMAGE_WIDTH, 0);
      write_register(CSR_IMAGE_HEIGHT, 1);
      send_frame(-1, CSR_IMAGE_HEIGHT, 0);
      write_register(CSR_IMAGE_WIDTH, 1);
      write_register(CSR_IMAGE_HEIGHT, 0);
      send_frame(-1, CSR_IMAGE_HEIGHT, 0);
      write_register(CSR_IMAGE_WIDTH, 1023);
      write_register(CSR_IMAGE_HEIGHT, 2);
      send_frame(48, CSR_IMAGE_WIDTH, 3);
   endtask

   task automatic test_tall_frame();
      write_register(CSR_IMAGE_WIDTH, 2);
      write_register(CSR_IMAGE_HEIGHT, 8191);
      send_frame(24, CSR_IMAGE_HEIGHT, 5);
   endtask

   task automatic test_width_shrink();
      write_register(CSR_IMAGE_WIDTH, 6);
      write_register(CSR_IMAGE_HEIGHT, 4);
      send_frame(16, CSR_IMAGE_WIDTH, 3);
   endtask

   task automatic test_back_pressure();
      write_register(CSR_IMAGE_WIDTH, 16);
      write_register(CSR_IMAGE_HEIGHT, 4);
      no_idle      = 1'b1;
      hold_request = 1'b1;
      send_frame(-1, CSR_IMAGE_HEIGHT, 0);
      no_idle = 1'b0;
   endtask

   task automatic test_random_frames();
      int first;
      int p;
      int change_at;
      int value;
      logic [CSR_INDEX_BITS-1:0] idx;
      first = words_sent;
      while (words_sent - first < RANDOM_WORDS) begin
         p = $urandom_range(0, 19);
         write_register(CSR_IMAGE_WIDTH, (p == 0) ? $urandom_range(0, 1) :
                        (p < 14) ? $urandom_range(2, 8) :
                        (p < 19) ? $urandom_range(9, 40) : $urandom_range(41, 128));
         p = $urandom_range(0, 19);
         write_register(CSR_IMAGE_HEIGHT, (p == 0) ? $urandom_range(0, 1) :
                        (p < 16) ? $urandom_range(2, 5) : $urandom_range(6, 12));
         no_idle   = ($urandom_range(0, 3) == 0);
         change_at = -1;
         idx       = CSR_IMAGE_HEIGHT;
         value     = 0;
         if ($urandom_range(0, 4) == 0) begin
            change_at = $urandom_range(0, active_width() * active_height());
            if ($urandom_range(0, 1)) begin
               value = $urandom_range(0, active_height() + 2);
            end else begin
               idx   = CSR_IMAGE_WIDTH;
               value = $urandom_range(0, active_width());
            end
         end
         send_frame(change_at, idx, value);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      win = '{default: '0};
      foreach (upper_line[i]) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_size();
      test_special_cases();
      test_register_limits();
      test_tall_frame();
      test_width_shrink();
      test_back_pressure();
      test_random_frames();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
